// ===== hw/rtl/sebs_pkg.sv =====
// Shared constants and types for the scaled embedding-bag sum block.
// Holds table geometry, field widths, opcodes and register indexes.
// No dependencies; every other file refers to it by scoped names.
package sebs_pkg;

    // Table geometry. EMB_DIM is a power of two so that a byte address is {row, column}.
    localparam int TABLE_ROWS = 1024;
    localparam int EMB_DIM    = 16;
    localparam int ROW_W      = 10;
    localparam int COL_W      = 4;
    localparam int BYTE_W     = 8;
    localparam int MEM_DEPTH  = TABLE_ROWS * EMB_DIM;
    localparam int MEM_AW     = $clog2(MEM_DEPTH);

    // Accumulator and element indexing.
    localparam int ACC_DEPTH  = 16;
    localparam int N_LIVE     = (EMB_DIM < ACC_DEPTH) ? EMB_DIM : ACC_DEPTH;
    localparam int IDX_W      = 4;
    localparam int ACC_W      = 40;
    localparam int DEC_W      = 19;

    // Scaling datapath.
    localparam int SCALE_W    = 32;
    localparam int HALF_W     = 16;
    localparam int MUL_B_W    = HALF_W + 1;
    localparam int PROD_W     = ACC_W + MUL_B_W;
    localparam int SUM_W      = PROD_W + 1;
    localparam int OUT_W      = 48;

    // Configuration registers.
    localparam int CFG_IDX_W  = 2;
    localparam int DIMS_W     = 5;
    localparam logic [CFG_IDX_W-1:0] REG_FORMAT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DIMS   = 2'd2;
    localparam logic                 FMT_INT8   = 1'b0;
    localparam logic                 FMT_FP8    = 1'b1;
    localparam logic [SCALE_W-1:0]   SCALE_RESET = 32'h0001_0000;
    localparam logic [DIMS_W-1:0]    DIMS_RESET  = 5'd16;

    // Input opcodes.
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    // Stream widths.
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 56;

    typedef logic signed [ACC_W-1:0] acc_t;
    typedef logic signed [DEC_W-1:0] dec_t;

endpackage

// ===== hw/rtl/scaled_embedding_bag_sum.sv =====
// Top level of the scaled embedding-bag sum block: table memory, accumulators,
// sequencer and the shared scaling multiplier.
// Depends on sebs_pkg for constants and types.

// The block keeps a 1024 x 16 byte table of quantized weights (signed int8 or
// fp8 e4m3fn, picked by the weight_format register) and sums table rows into
// a 16-element bag accumulator. An item with opcode 0 writes one table byte.
// An item with opcode 1 looks up a row: the single table read port delivers
// one byte per cycle, so the lookup holds the input side while its 16 bytes
// are read. Each byte is decoded exactly to fixed point in units of 2^-9 and
// added into its accumulator with 40-bit saturation; the first lookup of a
// bag overwrites instead of adding. When the lookup carries tlast, the block
// passes a drain state that finishes the last add and then produces
// dims_in_use result items (clamped to 1..16) through one shared 40 x 17
// multiplier: each element goes through low half product, high half product,
// recombine and round, and saturate into the output register, the last step
// waiting while the output side stalls. Results are rounded half up and
// saturated to 48 bits. A finished result waits in the output register while
// the block goes back to taking input items. Configuration writes are
// accepted in any cycle but may only be issued while the block is idle. Table
// bytes that were never written read as arbitrary values.
module scaled_embedding_bag_sum
(
    input  logic                                  clk,
    input  logic                                  rst_n,

    // Configuration write channel.
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [sebs_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [sebs_pkg::SCALE_W-1:0]          cfg_data,

    // Input items.
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // [9:0] row_index, [13:10] column, [21:14] weight_byte, [23:22] zero
    input  logic [sebs_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
    // [0] opcode
    input  logic                                  s_axis_tuser,
    // ends_bag
    input  logic                                  s_axis_tlast,

    // Result items.
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // [3:0] element, [51:4] pooled_value, [55:52] zero
    output logic [sebs_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    // last_of_run
    output logic                                  m_axis_tlast
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LOOK  = 3'd1;
    localparam logic [2:0] ST_DRAIN = 3'd2;
    localparam logic [2:0] ST_MLO   = 3'd3;
    localparam logic [2:0] ST_MHI   = 3'd4;
    localparam logic [2:0] ST_SUM   = 3'd5;
    localparam logic [2:0] ST_OUT   = 3'd6;

    // Configuration registers.
    logic                              fmt_reg;
    logic [sebs_pkg::SCALE_W-1:0]      scale_reg;
    logic [sebs_pkg::DIMS_W-1:0]       dims_reg;

    // Sequencer.
    logic [2:0]                        state_reg;
    logic [2:0]                        state_next;
    logic [sebs_pkg::IDX_W-1:0]        rd_cnt_reg;
    logic [sebs_pkg::IDX_W-1:0]        elem_reg;
    logic [sebs_pkg::ROW_W-1:0]        row_reg;
    logic                              row_ok_reg;
    logic                              ends_reg;
    logic                              first_reg;
    logic                              bag_open_reg;

    // Accumulate pipeline, one element behind the table read.
    logic                              acc_en_reg;
    logic [sebs_pkg::IDX_W-1:0]        acc_idx_reg;
    logic                              acc_ok_reg;

    // Table memory.
    logic [sebs_pkg::BYTE_W-1:0]       mem [0:sebs_pkg::MEM_DEPTH-1];
    logic [sebs_pkg::BYTE_W-1:0]       mem_q_reg;
    logic                              mem_we;
    logic [sebs_pkg::MEM_AW-1:0]       mem_waddr;
    logic [sebs_pkg::MEM_AW-1:0]       mem_raddr;

    // Accumulators and scaling datapath.
    sebs_pkg::acc_t                    acc_mem [0:sebs_pkg::ACC_DEPTH-1];
    sebs_pkg::acc_t                    acc_rd;
    logic [sebs_pkg::IDX_W-1:0]        acc_sel;
    sebs_pkg::dec_t                    dec_val;
    logic signed [sebs_pkg::ACC_W:0]   acc_sum;
    sebs_pkg::acc_t                    acc_new;
    logic signed [sebs_pkg::MUL_B_W-1:0] mul_b;
    logic signed [sebs_pkg::PROD_W-1:0]  mul_p;
    logic signed [sebs_pkg::PROD_W-1:0]  plo_reg;
    logic signed [sebs_pkg::PROD_W-1:0]  phi_reg;
    logic signed [sebs_pkg::SUM_W-1:0]   sum_reg;
    logic signed [sebs_pkg::SUM_W-1:0]   plo_rnd;
    logic signed [sebs_pkg::OUT_W-1:0]   sat_val;
    logic [sebs_pkg::IDX_W-1:0]        k_last;

    // Output register.
    logic                              out_valid_reg;
    logic [sebs_pkg::IDX_W-1:0]        out_elem_reg;
    logic [sebs_pkg::OUT_W-1:0]        out_val_reg;
    logic                              out_last_reg;
    logic                              out_free;

    // Input fields.
    logic [sebs_pkg::ROW_W-1:0]        in_row;
    logic [sebs_pkg::COL_W-1:0]        in_col;
    logic [sebs_pkg::BYTE_W-1:0]       in_byte;
    logic                              in_acc;

    function automatic sebs_pkg::dec_t decode_byte(input logic fmt, input logic [7:0] b);
        logic [3:0]  e;
        logic [2:0]  m;
        logic [17:0] mag;
        e   = b[6:3];
        m   = b[2:0];
        mag = '0;
        if (fmt == sebs_pkg::FMT_INT8)
        begin
            return {{2{b[7]}}, b, 9'b0};
        end
        if (e == 4'd15 && m == 3'd7)
        begin
            // NaN saturates to the largest finite magnitude, 448.
            mag = 18'd229376;
        end
        else if (e == 4'd0)
        begin
            mag = {15'd0, m};
        end
        else
        begin
            mag = {14'd0, 1'b1, m} << (e - 4'd1);
        end
        return b[7] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    endfunction

    assign in_row  = s_axis_tdata[9:0];
    assign in_col  = s_axis_tdata[13:10];
    assign in_byte = s_axis_tdata[21:14];
    assign in_acc  = s_axis_tvalid && s_axis_tready;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == ST_IDLE);

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg   <= sebs_pkg::FMT_INT8;
            scale_reg <= sebs_pkg::SCALE_RESET;
            dims_reg  <= sebs_pkg::DIMS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                sebs_pkg::REG_FORMAT: fmt_reg   <= cfg_data[0];
                sebs_pkg::REG_SCALE:  scale_reg <= cfg_data;
                sebs_pkg::REG_DIMS:   dims_reg  <= cfg_data[sebs_pkg::DIMS_W-1:0];
                default: ;
            endcase
        end
    end

    // Index of the final result of a bag.
    always_comb
    begin
        if (dims_reg == '0)
        begin
            k_last = '0;
        end
        else if (32'(dims_reg) > sebs_pkg::N_LIVE)
        begin
            k_last = sebs_pkg::IDX_W'(sebs_pkg::N_LIVE - 1);
        end
        else
        begin
            k_last = sebs_pkg::IDX_W'(dims_reg - 5'd1);
        end
    end

    // Table memory: one write port, one registered read port.
    assign mem_we    = in_acc && (s_axis_tuser == sebs_pkg::OP_WRITE)
                       && (32'(in_row) < sebs_pkg::TABLE_ROWS)
                       && (32'(in_col) < sebs_pkg::EMB_DIM);
    assign mem_waddr = {in_row, in_col};
    assign mem_raddr = {row_reg, rd_cnt_reg};

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= in_byte;
        end
        mem_q_reg <= mem[mem_raddr];
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && s_axis_tuser == sebs_pkg::OP_LOOKUP)
                begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                if (rd_cnt_reg == sebs_pkg::IDX_W'(sebs_pkg::N_LIVE - 1))
                begin
                    state_next = ends_reg ? ST_DRAIN : ST_IDLE;
                end
            end
            ST_DRAIN: state_next = ST_MLO;
            ST_MLO:   state_next = ST_MHI;
            ST_MHI:   state_next = ST_SUM;
            ST_SUM:   state_next = ST_OUT;
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = (elem_reg == k_last) ? ST_IDLE : ST_MLO;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            rd_cnt_reg   <= '0;
            elem_reg     <= '0;
            bag_open_reg <= 1'b0;
            acc_en_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            acc_en_reg <= (state_reg == ST_LOOK);
            if (in_acc && s_axis_tuser == sebs_pkg::OP_LOOKUP)
            begin
                bag_open_reg <= !s_axis_tlast;
                rd_cnt_reg   <= '0;
            end
            else if (state_reg == ST_LOOK)
            begin
                rd_cnt_reg <= rd_cnt_reg + 1'b1;
            end
            if (state_reg == ST_DRAIN)
            begin
                elem_reg <= '0;
            end
            else if (state_reg == ST_OUT && out_free)
            begin
                elem_reg <= elem_reg + 1'b1;
            end
        end
    end

    // Per-lookup payload.
    always_ff @(posedge clk)
    begin
        if (in_acc && s_axis_tuser == sebs_pkg::OP_LOOKUP)
        begin
            row_reg    <= in_row;
            row_ok_reg <= (32'(in_row) < sebs_pkg::TABLE_ROWS);
            ends_reg   <= s_axis_tlast;
            first_reg  <= !bag_open_reg;
        end
        acc_idx_reg <= rd_cnt_reg;
        acc_ok_reg  <= row_ok_reg;
    end

    // Accumulators share one read address between the add and the multiplier.
    assign acc_sel = acc_en_reg ? acc_idx_reg : elem_reg;
    assign acc_rd  = acc_mem[acc_sel];
    assign dec_val = acc_ok_reg ? decode_byte(fmt_reg, mem_q_reg) : '0;
    assign acc_sum = (sebs_pkg::ACC_W + 1)'(acc_rd) + (sebs_pkg::ACC_W + 1)'(dec_val);

    always_comb
    begin
        if (first_reg)
        begin
            acc_new = sebs_pkg::ACC_W'(dec_val);
        end
        else if (acc_sum[sebs_pkg::ACC_W] != acc_sum[sebs_pkg::ACC_W-1])
        begin
            // Overflow: clamp toward the sign of the true sum.
            acc_new = acc_sum[sebs_pkg::ACC_W] ? {1'b1, {(sebs_pkg::ACC_W-1){1'b0}}}
                                               : {1'b0, {(sebs_pkg::ACC_W-1){1'b1}}};
        end
        else
        begin
            acc_new = acc_sum[sebs_pkg::ACC_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc_en_reg)
        begin
            acc_mem[acc_idx_reg] <= acc_new;
        end
    end

    // Shared multiplier: the accumulator times the low (unsigned) or high
    // (signed) half of scale. The full product is phi * 2^16 + plo.
    assign mul_b = (state_reg == ST_MHI)
                   ? $signed({scale_reg[sebs_pkg::SCALE_W-1],
                              scale_reg[sebs_pkg::SCALE_W-1:sebs_pkg::HALF_W]})
                   : $signed({1'b0, scale_reg[sebs_pkg::HALF_W-1:0]});
    assign mul_p = sebs_pkg::PROD_W'(acc_rd) * sebs_pkg::PROD_W'(mul_b);

    // Round half up, then take the high part with an arithmetic shift.
    assign plo_rnd = (sebs_pkg::SUM_W'(plo_reg) + sebs_pkg::SUM_W'(32768))
                     >>> sebs_pkg::HALF_W;

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_MLO)
        begin
            plo_reg <= mul_p;
        end
        if (state_reg == ST_MHI)
        begin
            phi_reg <= mul_p;
        end
        if (state_reg == ST_SUM)
        begin
            sum_reg <= sebs_pkg::SUM_W'(phi_reg) + plo_rnd;
        end
    end

    // Saturate to 48 bits: the value fits when all bits above bit 46 agree.
    always_comb
    begin
        if ((&sum_reg[sebs_pkg::SUM_W-1:sebs_pkg::OUT_W-1])
            || !(|sum_reg[sebs_pkg::SUM_W-1:sebs_pkg::OUT_W-1]))
        begin
            sat_val = sum_reg[sebs_pkg::OUT_W-1:0];
        end
        else
        begin
            sat_val = sum_reg[sebs_pkg::SUM_W-1] ? {1'b1, {(sebs_pkg::OUT_W-1){1'b0}}}
                                                 : {1'b0, {(sebs_pkg::OUT_W-1){1'b1}}};
        end
    end

    // Output register.
    assign out_free = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == ST_OUT && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_OUT && out_free)
        begin
            out_elem_reg <= elem_reg;
            out_val_reg  <= sat_val;
            out_last_reg <= (elem_reg == k_last);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0, out_val_reg, out_elem_reg};
    assign m_axis_tlast  = out_last_reg;

    // The accumulate pipeline and the multiplier never compete for the
    // accumulator read port.
    assert property (@(posedge clk) disable iff (!rst_n)
        acc_en_reg |-> (state_reg != ST_MLO && state_reg != ST_MHI))
        else $error("accumulator read port conflict");

    // Once a row starts accumulating, all of its elements follow back to back.
    assert property (@(posedge clk) disable iff (!rst_n)
        (acc_en_reg && acc_idx_reg != sebs_pkg::IDX_W'(sebs_pkg::N_LIVE - 1)) |=> acc_en_reg)
        else $error("row accumulation interrupted");

    // The final result of a bag carries the last element index.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata[3:0] == k_last))
        else $error("bag result ends on wrong element");

endmodule
